// ===== sv/lpm_pkg.sv =====
// Shared widths, operation codes, result type, mask and length-clamp helpers for the route table.
package lpm_pkg;

   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 6;
   localparam int HOP_IN_W = 8;

   localparam logic [ADDR_W-1:0] FULL_MASK = 32'hFFFF_FFFF;
   localparam logic [LEN_W-1:0]  MAX_LEN   = 6'd32;

   localparam logic FUNC_ADD    = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   typedef struct packed {
      logic                hit;
      logic [HOP_IN_W-1:0] hop_out;
      logic                table_full;
      logic [LEN_W-1:0]    match_len;
   } rsp_type;

   // A length of zero gives an all-zero mask; lengths are already limited to 32.
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      prefix_mask = ~(FULL_MASK >> len);
   endfunction

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
      clamp_len = (len > MAX_LEN) ? MAX_LEN : len;
   endfunction

endpackage

// ===== sv/lpm_if.sv =====
// Request and response channel interfaces of the route table.
interface lpm_req_if import lpm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                func;
   logic [ADDR_W-1:0]   address;
   logic [LEN_W-1:0]    prefix_len;
   logic [HOP_IN_W-1:0] next_hop;

   modport source (output valid, output func, output address, output prefix_len,
                   output next_hop, input ready);
   modport sink   (input valid, input func, input address, input prefix_len,
                   input next_hop, output ready);
endinterface

interface lpm_rsp_if import lpm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                hit;
   logic [HOP_IN_W-1:0] hop_out;
   logic                table_full;
   logic [LEN_W-1:0]    match_len;

   modport source (output valid, output hit, output hop_out, output table_full,
                   output match_len, input ready);
   modport sink   (input valid, input hit, input hop_out, input table_full,
                   input match_len, output ready);
endinterface

// ===== sv/longest_prefix_match_table.sv =====
// IPv4 longest-prefix-match route table. Routes live in a single-port-read memory and are
// kept packed from entry 0 upward, so a fill count stands in for per-entry valid bits and
// no clearing pass follows reset. Every beat, add or lookup, walks the stored routes (at
// most ENTRIES) one per cycle through the memory read port. One item is in flight at a
// time; the next request beat is taken as soon as the current result has moved into the
// output register.
module longest_prefix_match_table import lpm_pkg::*; #(
   parameter int ENTRIES   = 16,
   parameter int HOP_WIDTH = 8
) (
   input  logic            clock,
   input  logic            reset,
   lpm_req_if.sink         req_ch,
   lpm_rsp_if.source       rsp_ch
);

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int WORD_W = ADDR_W + LEN_W + HOP_WIDTH;
   localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(ENTRIES);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_SCAN    = 4'b0010,
      ST_RESOLVE = 4'b0100,
      ST_HOLD    = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 func_ff, func_in;
   logic [ADDR_W-1:0]    key_ff, key_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [HOP_WIDTH-1:0] hop_ff, hop_in;
   logic                 found_ff, found_in;
   logic [LEN_W-1:0]     best_len_ff, best_len_in;
   logic [HOP_WIDTH-1:0] best_hop_ff, best_hop_in;
   logic [IDX_W-1:0]     same_idx_ff, same_idx_in;
   rsp_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [WORD_W-1:0]    wr_data;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic [WORD_W-1:0]    rd_data;

   logic [ADDR_W-1:0]    rd_prefix;
   logic [LEN_W-1:0]     rd_len;
   logic [HOP_WIDTH-1:0] rd_hop;
   logic                 issue_more;
   logic                 lookup_match;
   logic                 same_match;
   logic                 tbl_full;
   logic                 out_free;
   logic [LEN_W-1:0]     req_len;
   logic [HOP_WIDTH+HOP_IN_W-1:0] req_hop_ext;
   logic [HOP_WIDTH+HOP_IN_W-1:0] best_hop_ext;
   rsp_type              rs;

   lpm_route_ram #(
      .DEPTH (ENTRIES),
      .WIDTH (WORD_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_prefix = rd_data[WORD_W-1 -: ADDR_W];
   assign rd_len    = rd_data[HOP_WIDTH +: LEN_W];
   assign rd_hop    = rd_data[HOP_WIDTH-1:0];

   assign issue_more   = (issue_ff != count_ff);
   assign lookup_match = ((key_ff & prefix_mask(rd_len)) == rd_prefix);
   assign same_match   = (rd_prefix == key_ff) && (rd_len == len_ff);
   assign tbl_full     = (count_ff == ENTRIES_CNT);
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign req_len      = clamp_len(req_ch.prefix_len);
   assign req_hop_ext  = {{HOP_WIDTH{1'b0}}, req_ch.next_hop};
   assign best_hop_ext = {{HOP_IN_W{1'b0}}, best_hop_ff};

   assign rd_en   = (state_ff == ST_SCAN) && issue_more;
   assign rd_addr = issue_ff[IDX_W-1:0];

   // Result of the finished scan, valid in the resolve state.
   always_comb begin
      rs = '0;
      if (func_ff == FUNC_LOOKUP) begin
         rs.hit       = found_ff;
         rs.hop_out   = best_hop_ext[HOP_IN_W-1:0];
         rs.match_len = best_len_ff;
      end else begin
         rs.table_full = !found_ff && tbl_full;
      end
   end

   // Adds write back at most once, in the resolve state: over the same key, or at the fill point if there is room.
   assign wr_en   = (state_ff == ST_RESOLVE) && (func_ff == FUNC_ADD) && (found_ff || !tbl_full);
   assign wr_addr = found_ff ? same_idx_ff : count_ff[IDX_W-1:0];
   assign wr_data = {key_ff, len_ff, hop_ff};

   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      rd_pend_in   = 1'b0;
      rd_idx_in    = rd_idx_ff;
      func_in      = func_ff;
      key_in       = key_ff;
      len_in       = len_ff;
      hop_in       = hop_ff;
      found_in     = found_ff;
      best_len_in  = best_len_ff;
      best_hop_in  = best_hop_ff;
      same_idx_in  = same_idx_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               func_in     = req_ch.func;
               len_in      = req_len;
               key_in      = (req_ch.func == FUNC_ADD) ?
                             (req_ch.address & prefix_mask(req_len)) : req_ch.address;
               hop_in      = req_hop_ext[HOP_WIDTH-1:0];
               found_in    = 1'b0;
               best_len_in = '0;
               best_hop_in = '0;
               issue_in    = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue_more) begin
               rd_pend_in = 1'b1;
               rd_idx_in  = issue_ff[IDX_W-1:0];
               issue_in   = issue_ff + CNT_W'(1);
            end else begin
               state_in = ST_RESOLVE;
            end
            // The read issued last cycle is compared here.
            if (rd_pend_ff) begin
               if (func_ff == FUNC_LOOKUP) begin
                  if (lookup_match && (!found_ff || (rd_len > best_len_ff))) begin
                     found_in    = 1'b1;
                     best_len_in = rd_len;
                     best_hop_in = rd_hop;
                  end
               end else if (same_match && !found_ff) begin
                  found_in    = 1'b1;
                  same_idx_in = rd_idx_ff;
               end
            end
         end
         ST_RESOLVE: begin
            res_in = rs;
            if ((func_ff == FUNC_ADD) && !found_ff && !tbl_full) begin
               count_in = count_ff + CNT_W'(1);
            end
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rs;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff    <= issue_in;
      rd_idx_ff   <= rd_idx_in;
      func_ff     <= func_in;
      key_ff      <= key_in;
      len_ff      <= len_in;
      hop_ff      <= hop_in;
      found_ff    <= found_in;
      best_len_ff <= best_len_in;
      best_hop_ff <= best_hop_in;
      same_idx_ff <= same_idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.hit        = rsp_data_ff.hit;
   assign rsp_ch.hop_out    = rsp_data_ff.hop_out;
   assign rsp_ch.table_full = rsp_data_ff.table_full;
   assign rsp_ch.match_len  = rsp_data_ff.match_len;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ENTRIES_CNT)
      else $error("route count exceeds table depth");

   a_count_only_resolve: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_RESOLVE) |=> $stable(count_ff))
      else $error("route count changed outside the resolve step");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (issue_ff <= count_ff))
      else $error("scan read beyond the stored routes");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == ST_SCAN))
      else $error("memory read returned outside the scan");

   a_miss_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.hit) |->
      ((rsp_data_ff.hop_out == '0) && (rsp_data_ff.match_len == '0)))
      else $error("miss or add beat carries a next hop or length");
`endif

endmodule

// ===== sv/lpm_route_ram.sv =====
// Route storage: single write port, single read port with registered read data.
module lpm_route_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 46
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== tb/lpm_table_checker.sv =====
// Route table response checker: mirrors the table contents and compares every response beat.
module lpm_table_checker import lpm_pkg::*; #(
   parameter int ENTRIES   = 16,
   parameter int HOP_WIDTH = 8
) (
   input  logic clock,
   input  logic reset,
   lpm_req_if   req_mon,
   lpm_rsp_if   rsp_mon,
   output int   failures,
   output int   pending,
   output int   hit_count,
   output int   drop_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic                 route_valid [ENTRIES];
   logic [ADDR_W-1:0]    route_prefix[ENTRIES];
   logic [LEN_W-1:0]     route_len   [ENTRIES];
   logic [HOP_WIDTH-1:0] route_hop   [ENTRIES];

   rsp_type expected_rsps[$];
   rsp_type want;
   rsp_type got;

   function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
      if (len == 0) return '0;
      return FULL_MASK << (ADDR_W - len);
   endfunction

   // Applies one request beat to the mirrored table and returns the response it should give.
   function automatic rsp_type route_table_apply(input logic func,
                                                 input logic [ADDR_W-1:0] addr,
                                                 input logic [LEN_W-1:0] len_in,
                                                 input logic [HOP_IN_W-1:0] hop);
      rsp_type           r;
      logic [LEN_W-1:0]  len;
      logic [ADDR_W-1:0] key;
      int                same;
      int                free_slot;
      logic              found;
      r = '0;
      len = (len_in > MAX_LEN) ? MAX_LEN : len_in;
      if (func == FUNC_ADD) begin
         key = addr & len_mask(len);
         same = -1;
         free_slot = -1;
         for (int i = 0; i < ENTRIES; i++) begin
            if (route_valid[i]) begin
               if (same < 0 && route_prefix[i] == key && route_len[i] == len) same = i;
            end else if (free_slot < 0) begin
               free_slot = i;
            end
         end
         if (same >= 0) begin
            route_hop[same] = HOP_WIDTH'(hop);
         end else if (free_slot >= 0) begin
            route_valid[free_slot]  = 1'b1;
            route_prefix[free_slot] = key;
            route_len[free_slot]    = len;
            route_hop[free_slot]    = HOP_WIDTH'(hop);
         end else begin
            r.table_full = 1'b1;
         end
      end else begin
         found = 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (route_valid[i] && (addr & len_mask(route_len[i])) == route_prefix[i] &&
                (!found || route_len[i] > r.match_len)) begin
               found       = 1'b1;
               r.hit       = 1'b1;
               r.match_len = route_len[i];
               r.hop_out   = HOP_IN_W'(route_hop[i]);
            end
         end
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] expected_value,
                              input logic [31:0] actual_value);
      if (actual_value !== expected_value) begin
         failures++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name,
                  expected_value, actual_value);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) route_valid[i] = 1'b0;
         expected_rsps.delete();
         failures   = 0;
         hit_count  = 0;
         drop_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            want = route_table_apply(req_mon.func, req_mon.address, req_mon.prefix_len,
                                     req_mon.next_hop);
            if (want.hit) hit_count++;
            if (want.table_full) drop_count++;
            expected_rsps.push_back(want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.hit        = rsp_mon.hit;
            got.hop_out    = rsp_mon.hop_out;
            got.table_full = rsp_mon.table_full;
            got.match_len  = rsp_mon.match_len;
            if (expected_rsps.size() == 0) begin
               failures++;
               $display("%0t: response beat with none expected, got hit %0d hop %0d full %0d len %0d",
                        $time, got.hit, got.hop_out, got.table_full, got.match_len);
            end else begin
               want = expected_rsps.pop_front();
               check_field("hit", 32'(want.hit), 32'(got.hit));
               check_field("hop_out", 32'(want.hop_out), 32'(got.hop_out));
               check_field("table_full", 32'(want.table_full), 32'(got.table_full));
               check_field("match_len", 32'(want.match_len), 32'(got.match_len));
            end
         end
      end
      pending = expected_rsps.size();
   end

endmodule

// ===== tb/longest_prefix_match_table_test.sv =====
// Top of the route table testbench: clock, reset, request and response traffic, verdict.
module longest_prefix_match_table_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lpm_pkg::*;

   localparam int ENTRIES         = 16;
   localparam int HOP_WIDTH       = 8;
   localparam int RANDOM_BEATS    = 1523;
   localparam int RSP_HOLD_CYCLES = 300;

   logic clock    = 1'b0;
   logic reset    = 1'b1;
   logic hold_rsp = 1'b0;
   int   failures;
   int   pending;
   int   hit_count;
   int   drop_count;
   int   beats_sent   = 0;
   int   lookups_sent = 0;
   int   steady_beats = 0;

   // Addresses and lengths of the routes known to be stored, used to aim lookups and rewrites.
   logic [ADDR_W-1:0] route_addrs[$];
   logic [LEN_W-1:0]  route_lens[$];

   lpm_req_if req_ch();
   lpm_rsp_if rsp_ch();

   longest_prefix_match_table #(.ENTRIES(ENTRIES), .HOP_WIDTH(HOP_WIDTH)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   lpm_table_checker #(.ENTRIES(ENTRIES), .HOP_WIDTH(HOP_WIDTH)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .failures   (failures),
      .pending    (pending),
      .hit_count  (hit_count),
      .drop_count (drop_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_beat(input logic func, input logic [ADDR_W-1:0] addr,
                            input logic [LEN_W-1:0] len, input logic [HOP_IN_W-1:0] hop);
      int gap;
      int pick;
      req_ch.valid      <= 1'b1;
      req_ch.func       <= func;
      req_ch.address    <= addr;
      req_ch.prefix_len <= len;
      req_ch.next_hop   <= hop;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      beats_sent++;
      if (func == FUNC_LOOKUP) begin
         lookups_sent++;
      end else if (route_addrs.size() < ENTRIES) begin
         // The directed part stores exactly ENTRIES distinct keys before any rewrite.
         route_addrs.push_back(addr);
         route_lens.push_back(len);
      end
      if (steady_beats > 0) begin
         steady_beats--;
         gap = 0;
      end else begin
         pick = $urandom_range(99);
         if (pick < 55) gap = 0;
         else if (pick < 88) gap = $urandom_range(1, 3);
         else if (pick < 96) gap = $urandom_range(4, 12);
         else gap = $urandom_range(20, 40);
      end
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Response side: short random stalls, occasional long ones, steady stretches, one long hold.
   initial begin
      int   run;
      int   pick;
      logic level;
      rsp_ch.ready <= 1'b0;
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            level = 1'b0;
            run = RSP_HOLD_CYCLES;
         end else begin
            pick = $urandom_range(99);
            if (pick < 10) begin
               level = 1'b1;
               run = $urandom_range(30, 120);
            end else if (pick < 15) begin
               level = 1'b0;
               run = $urandom_range(15, 40);
            end else begin
               level = ($urandom_range(2) != 0);
               run = $urandom_range(1, 3);
            end
         end
         @(posedge clock);
         rsp_ch.ready <= level;
         repeat (run - 1) @(posedge clock);
      end
   end

   initial begin
      int                  pick;
      int                  idx;
      int                  keep;
      int                  drain;
      logic [ADDR_W-1:0]   base;
      logic [ADDR_W-1:0]   addr;
      logic [LEN_W-1:0]    len;
      req_ch.valid      <= 1'b0;
      req_ch.func       <= FUNC_ADD;
      req_ch.address    <= '0;
      req_ch.prefix_len <= '0;
      req_ch.next_hop   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_beat(FUNC_LOOKUP, 32'hFFFF_FFFF, 6'd63, 8'hFF);   // empty table misses
      send_beat(FUNC_ADD,    32'h0A12_3456, 6'd8,  8'h01);   // low bits masked off
      send_beat(FUNC_LOOKUP, 32'h0B00_0000, 6'd0,  8'h00);   // no route matches
      send_beat(FUNC_ADD,    32'h0A01_0203, 6'd16, 8'h02);
      send_beat(FUNC_ADD,    32'h0A01_0203, 6'd24, 8'h03);
      send_beat(FUNC_ADD,    32'hFFFF_FFFF, 6'd32, 8'hFF);
      send_beat(FUNC_ADD,    32'hC0A8_0101, 6'd33, 8'h00);   // lengths above 32 saturate
      send_beat(FUNC_ADD,    32'hC0A8_01FF, 6'd63, 8'h05);
      send_beat(FUNC_ADD,    32'h0A01_0203, 6'd32, 8'h04);
      send_beat(FUNC_LOOKUP, 32'h0A01_0203, 6'd5,  8'h5A);
      send_beat(FUNC_LOOKUP, 32'h0A01_02FE, 6'd40, 8'hA5);
      send_beat(FUNC_ADD,    32'h1234_5678, 6'd0,  8'hAA);   // default route
      send_beat(FUNC_LOOKUP, 32'h0000_0000, 6'd0,  8'h00);
      // A chain of nested routes fills the table.
      for (int i = 0; i < 8; i++) begin
         send_beat(FUNC_ADD, 32'hA5C3_5A3C, LEN_W'(4 * (i + 1)), HOP_IN_W'(16 + i));
      end
      send_beat(FUNC_LOOKUP, 32'hA5C3_5A3C, 6'd0,  8'h00);
      send_beat(FUNC_ADD,    32'h0A01_0299, 6'd24, 8'h80);   // same key rewritten on a full table
      send_beat(FUNC_LOOKUP, 32'h0A01_0277, 6'd24, 8'h00);
      send_beat(FUNC_ADD,    32'h0102_0304, 6'd32, 8'h09);   // new key with no room is dropped
      send_beat(FUNC_ADD,    32'h0000_0000, 6'd0,  8'h55);
      send_beat(FUNC_LOOKUP, 32'h7FFF_FFFF, 6'd63, 8'hFF);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (n % 150 == 75) steady_beats = $urandom_range(20, 60);
         if (n == 400) begin
            // Keep offering beats while the response side is held, so the block backs up.
            hold_rsp = 1'b1;
            steady_beats = 60;
         end
         if (n == 800 || n == 1200) begin
            req_ch.valid <= 1'b0;
            @(posedge clock);
            wait (pending == 0);
            @(posedge clock);
         end
         pick = $urandom_range(99);
         idx  = $urandom_range(route_addrs.size() - 1);
         base = route_addrs[idx];
         keep = $urandom_range(32);
         if (pick < 55) begin
            if ($urandom_range(3) != 0)
               addr = (base & ~(FULL_MASK >> keep)) | ($urandom() & (FULL_MASK >> keep));
            else
               addr = $urandom();
            send_beat(FUNC_LOOKUP, addr, LEN_W'($urandom_range(63)), HOP_IN_W'($urandom()));
         end else if (pick < 85) begin
            // Rewrite a stored route; bits below its prefix are random and masked away.
            len  = route_lens[idx];
            addr = (base & ~(FULL_MASK >> len)) | ($urandom() & (FULL_MASK >> len));
            send_beat(FUNC_ADD, addr, len, HOP_IN_W'($urandom()));
         end else if (pick < 95) begin
            send_beat(FUNC_ADD, $urandom(), LEN_W'($urandom_range(63)), HOP_IN_W'($urandom()));
         end else begin
            send_beat(FUNC_ADD, base, LEN_W'($urandom_range(63)), HOP_IN_W'($urandom()));
         end
      end

      req_ch.valid <= 1'b0;
      drain = 0;
      do begin
         @(posedge clock);
         drain++;
      end while (pending != 0 && drain < 20000);
      repeat (40) @(posedge clock);

      if (pending != 0) $display("%0t: %0d expected responses never arrived", $time, pending);
      $display("Sent %0d request beats (%0d lookups); %0d lookups hit a route, %0d adds dropped.",
               beats_sent, lookups_sent, hit_count, drop_count);
      $display("Responses were held off for %0d cycles once and the sender drained twice.",
               RSP_HOLD_CYCLES);
      if (failures == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #10ms;
      $display("%0t: run did not finish in time", $time);
      $display("Test completed with failures");
      $finish;
   end

endmodule
